@@ rtl/core/tafo_pkg.sv @@
// Shared types and constants for the Thumb flag-setting ALU block.
package tafo_pkg;

	// Instruction kinds; code 7 is a no-op
	typedef enum logic [2:0] {
		KIND_ANDS = 3'd0,
		KIND_ADCS = 3'd1,
		KIND_ADDS = 3'd2,
		KIND_BICS = 3'd3,
		KIND_LSLS = 3'd4,
		KIND_ASRS = 3'd5,
		KIND_LOAD = 3'd6
	} kind_t;

	// NZCV bit positions
	localparam int FLAG_N_BIT = 3;
	localparam int FLAG_Z_BIT = 2;
	localparam int FLAG_C_BIT = 1;
	localparam int FLAG_V_BIT = 0;

	localparam int DATA_W  = 32;
	localparam int INDEX_W = 4;

	// Controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

endpackage

@@ rtl/core/tafo_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module tafo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

@@ rtl/core/tafo_ctrl.sv @@
// Controller state machine: accepts a beat, sequences read and execute.
module tafo_ctrl import tafo_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   done_q;

	// state register and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_EXEC);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy        = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = start;
			end
			ST_EXEC: begin
				busy        = 1'b1;
				cmd.execute = 1'b1;
			end
			default: busy = 1'b0;
		endcase
	end

	assign done = done_q;

endmodule

@@ rtl/core/tafo_dp.sv @@
// Datapath: register file with valid bits, NZCV flags, ALU and shifter.
module tafo_dp import tafo_pkg::*; #(
	parameter int NUM_REGS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [2:0]         kind,
	input  logic [INDEX_W-1:0] dest_index,
	input  logic [INDEX_W-1:0] src_index,
	input  logic [DATA_W-1:0]  load_value,
	output logic [DATA_W-1:0]  result_value,
	output logic [3:0]         flags_out
);

	localparam int AW = $clog2(NUM_REGS);
	localparam logic [INDEX_W:0] NREGS = (INDEX_W+1)'(NUM_REGS);

	// captured beat
	logic [2:0]         kind_q;
	logic [INDEX_W-1:0] dst_q;
	logic [DATA_W-1:0]  load_q;
	logic               a_vld_q;
	logic               b_vld_q;

	logic [NUM_REGS-1:0] valid_q;
	logic [3:0]          flags_q;
	logic [DATA_W-1:0]   res_q;

	logic dst_ok, src_ok;
	logic [DATA_W-1:0] ram_a, ram_b, a, b;

	logic              wr_en;
	logic [DATA_W-1:0] r;
	logic [3:0]        f;

	assign dst_ok = {1'b0, dest_index} < NREGS;
	assign src_ok = {1'b0, src_index} < NREGS;

	// capture of the request beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= kind;
			dst_q    <= dest_index;
			load_q   <= load_value;
			a_vld_q  <= dst_ok && valid_q[dest_index[AW-1:0]];
			b_vld_q  <= src_ok && valid_q[src_index[AW-1:0]];
		end
	end

	// in-range check for the write, kept apart from the read valid
	logic dst_in_q;
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dst_in_q <= dst_ok;
		end
	end

	tafo_ram #(
		.WIDTH(DATA_W),
		.DEPTH(NUM_REGS)
	) u_regs (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (dst_q[AW-1:0]),
		.wdata   (r),
		.re      (cmd.capture),
		.raddr_a (dest_index[AW-1:0]),
		.raddr_b (src_index[AW-1:0]),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	// never-written or out-of-range registers read as zero
	assign a = a_vld_q ? ram_a : '0;
	assign b = b_vld_q ? ram_b : '0;

	// ALU and shifter
	logic [DATA_W:0]   sum;
	logic              cin;
	logic [7:0]        n;
	logic [5:0]        sh;
	logic [DATA_W:0]   lsl_ext;
	logic [DATA_W:0]   asr_ext;
	logic              set_nz;

	always_comb begin
		n       = b[7:0];
		cin     = (kind_q == KIND_ADCS) && flags_q[FLAG_C_BIT];
		sum     = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, cin};
		sh      = (n > 8'd32) ? 6'd32 : n[5:0];
		lsl_ext = {1'b0, a} << sh;
		asr_ext = $unsigned($signed({a, 1'b0}) >>> sh);
		r       = a;
		f       = flags_q;
		wr_en   = 1'b0;
		set_nz  = 1'b0;
		case (kind_q) inside
			KIND_ANDS, KIND_BICS: begin
				r      = (kind_q == KIND_ANDS) ? (a & b) : (a & ~b);
				set_nz = 1'b1;
				wr_en  = 1'b1;
			end
			KIND_ADCS, KIND_ADDS: begin
				r              = sum[DATA_W-1:0];
				f[FLAG_C_BIT]  = sum[DATA_W];
				f[FLAG_V_BIT]  = ~(a[DATA_W-1] ^ b[DATA_W-1]) & (a[DATA_W-1] ^ r[DATA_W-1]);
				set_nz         = 1'b1;
				wr_en          = 1'b1;
			end
			KIND_LSLS: begin
				// count above 32 clears both result and carry
				if (n > 8'd32) begin
					r             = '0;
					f[FLAG_C_BIT] = 1'b0;
				end else if (n != 8'd0) begin
					r             = lsl_ext[DATA_W-1:0];
					f[FLAG_C_BIT] = lsl_ext[DATA_W];
				end
				set_nz = 1'b1;
				wr_en  = 1'b1;
			end
			KIND_ASRS: begin
				// count is clamped to 32, which yields sign fill and sign carry
				if (n != 8'd0) begin
					r             = asr_ext[DATA_W:1];
					f[FLAG_C_BIT] = asr_ext[0];
				end
				set_nz = 1'b1;
				wr_en  = 1'b1;
			end
			KIND_LOAD: begin
				r     = load_q;
				wr_en = 1'b1;
			end
			default: begin
				r     = a;
				wr_en = 1'b0;
			end
		endcase
		if (set_nz) begin
			f[FLAG_N_BIT] = r[DATA_W-1];
			f[FLAG_Z_BIT] = (r == '0);
		end
		wr_en = wr_en && dst_in_q && cmd.execute;
	end

	// valid bits and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			flags_q <= '0;
		end else begin
			if (wr_en) begin
				valid_q[dst_q[AW-1:0]] <= 1'b1;
			end
			if (cmd.execute) begin
				flags_q <= f;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			res_q <= r;
		end
	end

	assign result_value = res_q;
	assign flags_out    = flags_q;

endmodule

@@ rtl/core/thumb_alu_flag_ops_top.sv @@
// Sequence: capture of an accepted beat registers the register file read; the execute
// state then computes, writes back and registers the result and flags, strobed by done.
// A new beat is taken only in idle, so not while the block is busy executing the last one.
// The result strobe is single-cycle; the receiver cannot stall it.
// Reset: flags clear and every register reads as zero through per-register valid bits;
// no clearing pass is needed, so start is taken right after reset.
module thumb_alu_flag_ops_top import tafo_pkg::*; #(
	parameter int NUM_REGS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         kind,
	input  logic [INDEX_W-1:0] dest_index,
	input  logic [INDEX_W-1:0] src_index,
	input  logic [DATA_W-1:0]  load_value,
	output logic               done,
	output logic [DATA_W-1:0]  result_value,
	output logic [3:0]         flags_out
);

	cmd_t cmd;

	tafo_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	tafo_dp #(
		.NUM_REGS(NUM_REGS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.kind         (kind),
		.dest_index   (dest_index),
		.src_index    (src_index),
		.load_value   (load_value),
		.result_value (result_value),
		.flags_out    (flags_out)
	);

	// an accepted beat always moves the block into its busy phase
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	// end of the execute phase always presents a result
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result strobe");

	// a result only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without prior execute");

	// commands to the datapath never overlap
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.execute))
		else $error("capture and execute issued together");

endmodule
